// ===== hdl/sdw_pkg.sv =====
`timescale 1ns / 1ps

package sdw_pkg;

  // Segment pattern that shows the cursor on a digit.
  localparam logic [15:0] SegCursor = 16'hffff;

  // Range of character codes that the segment ROM defines.
  localparam logic [6:0] RomFirst = 7'h20;
  localparam logic [6:0] RomLast  = 7'h5f;

  // Number of digits on the display.
  localparam int unsigned NumDigits = 4;

  typedef logic [1:0]  digit_idx_t;
  typedef logic [15:0] seg_pat_t;
  typedef logic [6:0]  char_code_t;

  // Segment ROM for codes from RomFirst up to RomLast.
  localparam seg_pat_t SegRom [64] = '{
    16'h0000, 16'h2421, 16'h0480, 16'h0f3c, 16'h0fbb, 16'h5f99, 16'ha579, 16'h4000,
    16'hc000, 16'h3000, 16'hff00, 16'h0f00, 16'h1000, 16'h0300, 16'h0020, 16'h5000,
    16'h0ce1, 16'h0c00, 16'h0561, 16'h0d21, 16'h0d80, 16'h09a1, 16'h09e1, 16'h0c01,
    16'h0de1, 16'h0da1, 16'h0021, 16'h1001, 16'h5030, 16'h0330, 16'ha030, 16'h0a07,
    16'h097f, 16'h03cf, 16'h0e3f, 16'h00f3, 16'h0c3f, 16'h01f3, 16'h01c3, 16'h02fb,
    16'h03cc, 16'h0c33, 16'h0c63, 16'hc1c0, 16'h00f0, 16'h60cc, 16'ha0cc, 16'h00ff,
    16'h03c7, 16'h80ff, 16'h83c7, 16'h03bb, 16'h0c03, 16'h00fc, 16'h50c0, 16'h90cc,
    16'hf000, 16'h6800, 16'h5033, 16'h00e1, 16'ha000, 16'h001e, 16'h9000, 16'h0030
  };

endpackage

// ===== hdl/sdw_in_if.sv =====
`timescale 1ns / 1ps

// Bus write channel into the display controller.
interface sdw_in_if;
  import sdw_pkg::*;

  logic       valid;
  logic       ready;
  logic       chip_sel;
  logic       wr_en;
  logic       cursor_cmd;
  digit_idx_t position;
  char_code_t char_code;

  modport source (
    output valid, chip_sel, wr_en, cursor_cmd, position, char_code,
    input  ready
  );

  modport sink (
    input  valid, chip_sel, wr_en, cursor_cmd, position, char_code,
    output ready
  );
endinterface

// ===== hdl/sdw_out_if.sv =====
`timescale 1ns / 1ps

// Digit update channel out of the display controller.
interface sdw_out_if;
  import sdw_pkg::*;

  logic       valid;
  logic       ready;
  digit_idx_t digit_index;
  seg_pat_t   segments;
  logic       last;

  modport source (
    output valid, digit_index, segments, last,
    input  ready
  );

  modport sink (
    input  valid, digit_index, segments, last,
    output ready
  );
endinterface

// ===== hdl/segment_display_digit_writer_core.sv =====
`timescale 1ns / 1ps

// Four-digit sixteen-segment display controller.
// The in_i channel carries one bus write per transfer: enables, digit position and
// a seven-bit code. The out_o channel carries digit updates (digit index, segment
// pattern, last flag); last marks the final update of a write. A write that is not
// selected by both enables produces no update.
// Character writes and variant B cursor writes load their update into the output
// register from the evaluate state that follows the transfer, and in_i is ready
// again once the sequencer is back in idle. A variant T cursor write reads the
// four digits one per cycle from the digit memory while the output can take its
// updates, and holds one update back to learn which one is last; its final update
// is loaded from the flush state and the next write is taken back in idle. The
// digit memory has registered read data; one write is in flight at a time.
// Reset clears the digit memory through per-digit valid bits (no clearing pass),
// selects variant T and empties the output register. When the receiver stalls,
// the update waits in the output register and the sequencer holds until it can
// hand over the next one. cfg_we_i writes the variant bit (0 = B, 1 = T).
module segment_display_digit_writer_core
  import sdw_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_we_i,
  input  logic      cfg_wdata_i,
  sdw_in_if.sink    in_i,
  sdw_out_if.source out_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EVAL,
    ST_FLUSH
  } state_e;

  state_e     state_q, state_d;
  logic       variant_q;
  logic       cursor_q;
  logic       tcur_q;
  logic       var_q;
  digit_idx_t pos_q;
  char_code_t code_q;
  digit_idx_t cnt_q;
  logic       pend_q;
  digit_idx_t pend_idx_q;
  seg_pat_t   pend_seg_q;
  logic       out_valid_q;
  digit_idx_t out_idx_q;
  seg_pat_t   out_seg_q;
  logic       out_last_q;

  // Digit memory with registered read data and per-digit valid bits.
  seg_pat_t                 dig_mem [NumDigits];
  logic [NumDigits-1:0]     dig_vld_q;
  seg_pat_t                 rd_data_q;
  logic                     rd_vld_q;

  logic       in_take;
  logic       rd_en;
  digit_idx_t rd_addr;
  logic       mem_we;
  logic       out_free;
  logic       out_load;
  digit_idx_t out_idx_d;
  seg_pat_t   out_seg_d;
  logic       out_last_d;
  logic       pend_set;
  logic       pend_clr;
  logic       cnt_inc;
  seg_pat_t   old_seg;
  logic       code_def;
  seg_pat_t   char_seg;
  logic       char_store;
  seg_pat_t   t_seg;
  logic       t_emit;

  // Decode of the digit that was read last and of the latched code.
  always_comb begin
    old_seg    = rd_vld_q ? rd_data_q : '0;
    code_def   = (code_q >= RomFirst) && (code_q <= RomLast);
    char_seg   = code_def ? SegRom[6'(code_q - RomFirst)] : '0;
    char_store = !var_q || (old_seg != SegCursor) || !code_def;
    t_seg      = code_q[cnt_q] ? SegCursor : old_seg;
    t_emit     = (t_seg != old_seg);
    out_free   = !out_valid_q || out_o.ready;
    in_take    = in_i.valid && in_i.ready;
  end

  // Sequencer decisions.
  always_comb begin
    state_d    = state_q;
    in_i.ready = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = pos_q;
    mem_we     = 1'b0;
    out_load   = 1'b0;
    out_idx_d  = pos_q;
    out_seg_d  = char_seg;
    out_last_d = 1'b1;
    pend_set   = 1'b0;
    pend_clr   = 1'b0;
    cnt_inc    = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_i.valid && in_i.chip_sel && in_i.wr_en) begin
          rd_en   = 1'b1;
          rd_addr = (in_i.cursor_cmd && variant_q) ? '0 : in_i.position;
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!cursor_q) begin
          // Character write: store and show, unless a T cursor blocks it.
          if (!char_store) begin
            state_d = ST_IDLE;
          end else if (out_free) begin
            out_load = 1'b1;
            mem_we   = 1'b1;
            state_d  = ST_IDLE;
          end
        end else if (!tcur_q) begin
          // Variant B cursor: show the cursor or restore the stored digit.
          if (out_free) begin
            out_load  = 1'b1;
            out_seg_d = code_q[0] ? SegCursor : old_seg;
            state_d   = ST_IDLE;
          end
        end else if (!(t_emit && pend_q && !out_free)) begin
          // Variant T cursor: hand off the held update once a newer one exists.
          if (t_emit && pend_q) begin
            out_load   = 1'b1;
            out_idx_d  = pend_idx_q;
            out_seg_d  = pend_seg_q;
            out_last_d = 1'b0;
          end
          pend_set = t_emit;
          if (cnt_q == digit_idx_t'(NumDigits - 1)) begin
            state_d = ST_FLUSH;
          end else begin
            rd_en   = 1'b1;
            rd_addr = cnt_q + 2'd1;
            cnt_inc = 1'b1;
          end
        end
      end
      ST_FLUSH: begin
        if (!pend_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_load  = 1'b1;
          out_idx_d = pend_idx_q;
          out_seg_d = pend_seg_q;
          pend_clr  = 1'b1;
          state_d   = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State, control registers and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      variant_q   <= 1'b1;
      cursor_q    <= 1'b0;
      tcur_q      <= 1'b0;
      var_q       <= 1'b1;
      cnt_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_idx_q   <= '0;
      out_seg_q   <= '0;
      out_last_q  <= 1'b0;
      dig_vld_q   <= '0;
      rd_vld_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        variant_q <= cfg_wdata_i;
      end
      if (in_take) begin
        cursor_q <= in_i.cursor_cmd;
        tcur_q   <= in_i.cursor_cmd && variant_q;
        var_q    <= variant_q;
        cnt_q    <= '0;
        pend_q   <= 1'b0;
      end else begin
        if (cnt_inc) begin
          cnt_q <= cnt_q + 2'd1;
        end
        if (pend_set) begin
          pend_q <= 1'b1;
        end else if (pend_clr) begin
          pend_q <= 1'b0;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_idx_q   <= out_idx_d;
        out_seg_q   <= out_seg_d;
        out_last_q  <= out_last_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (mem_we) begin
        dig_vld_q[pos_q] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= dig_vld_q[rd_addr];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      pos_q  <= in_i.position;
      code_q <= in_i.char_code;
    end
    if (pend_set) begin
      pend_idx_q <= cnt_q;
      pend_seg_q <= t_seg;
    end
  end

  // Digit memory: one write or one read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dig_mem[pos_q] <= char_seg;
    end
    if (rd_en) begin
      rd_data_q <= dig_mem[rd_addr];
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.digit_index = out_idx_q;
  assign out_o.segments    = out_seg_q;
  assign out_o.last        = out_last_q;

  // A stored character marks its digit as written.
  a_store_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |=> dig_vld_q[$past(pos_q)])
    else $error("digit valid bit not set after store");

  // The ROM never yields the cursor pattern, so it is never stored.
  a_no_cursor_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mem_we |-> (char_seg != SegCursor))
    else $error("cursor pattern written into digit memory");

  // Only a variant T cursor write holds an update back.
  a_pend_tcursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> tcur_q && (state_q == ST_EVAL || state_q == ST_FLUSH))
    else $error("held update outside a cursor sweep");

  // Handing off the final update of a write frees the sequencer.
  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && out_last_d) |=> (state_q == ST_IDLE))
    else $error("sequencer busy after final update");

endmodule
